>>> hdl/assert_macros.svh
// Assertion macros shared by the ambient-subtract RTL.
// No dependencies; included by modules that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Plain property, checked on the rising clock edge outside reset
`define AMS_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);
// Same-cycle implication
`define AMS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`else
`define AMS_ASSERT(label, clk, rst_n, prop, msg)
`define AMS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`endif
`endif

>>> hdl/ams_pkg.sv
// Shared types and constants for the ambient-subtract block.
// No dependencies; used by the interface users, controller, datapath and top.
package ams_pkg;

    localparam int DATA_W         = 16;
    localparam int WLEN_W         = 4;
    localparam int NUM_SENSORS    = 7;
    localparam int SENS_W         = $clog2(NUM_SENSORS);
    localparam int DEF_NUM_BOARDS = 2;
    localparam int DEF_MAX_WINDOW = 10;

    typedef logic [DATA_W-1:0] t_word;
    typedef logic [WLEN_W-1:0] t_wlen;

    localparam t_word DATA_MAX = 16'hFFFF;

    // Sensor index feeding each eye output (eye order 1,2,4,5,3,6,7)
    localparam logic [SENS_W-1:0] EYE_SRC [NUM_SENSORS] = '{
        SENS_W'(0), SENS_W'(1), SENS_W'(3), SENS_W'(4),
        SENS_W'(2), SENS_W'(5), SENS_W'(6)
    };

    typedef struct packed {
        logic  board;
        t_word vref_word;
        t_word raw_1;
        t_word raw_2;
        t_word raw_3;
        t_word raw_4;
        t_word raw_5;
        t_word raw_6;
        t_word raw_7;
    } t_in_item;

    typedef struct packed {
        t_word vref_out;
        t_word eye_1;
        t_word eye_2;
        t_word eye_3;
        t_word eye_4;
        t_word eye_5;
        t_word eye_6;
        t_word eye_7;
    } t_out_item;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic wr_en;
        logic rd_en;
        logic mod_step;
        logic commit;
        logic emit;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic start_ok;
        logic sens_last;
        logic scan_last;
        logic filling;
        logic mod_done;
        logic out_free;
    } t_dp_stat;

endpackage

>>> hdl/ams_stream_if.sv
// Valid/ready channel carrying one item of type T.
// No dependencies; payload types come from ams_pkg at the point of use.
interface ams_stream_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

>>> hdl/ir_ambient_min_subtract_core.sv
// Ambient-subtract top (controller + datapath, ams_pkg): window minimum removed per frame.
// A storing frame (window still filling) goes through write and slot wrap; a result frame goes
// through write, a scan of the window rows at one memory read per cycle, drain, slot wrap and
// emit. A new item is taken only in idle, after the last one is through; an output stall holds emit.
// Sync active-low reset clears state; window length resets to the window depth.
module ir_ambient_min_subtract_core
    import ams_pkg::*;
#(
    parameter int NUM_BOARDS = DEF_NUM_BOARDS,
    parameter int MAX_WINDOW = DEF_MAX_WINDOW
) (
    input logic           i_clk,
    input logic           i_rst_n,
    ams_stream_if.sink    i_in,
    ams_stream_if.source  o_out,
    ams_stream_if.sink    i_cfg
);

    t_dp_cmd  cmd;
    t_dp_stat stat;
    logic     in_ready;

    // Config register always accepts
    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = in_ready;

    ams_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    ams_dpath #(
        .NUM_BOARDS (NUM_BOARDS),
        .MAX_WINDOW (MAX_WINDOW)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_item   (i_in.payload),
        .i_cfg_valid (i_cfg.valid),
        .i_cfg_data  (i_cfg.payload),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .o_out_item  (o_out.payload)
    );

endmodule

>>> hdl/ams_ctrl.sv
// Sequencer for the ambient-subtract block: store, scan, slot wrap, emit.
// Depends on ams_pkg (command and status structs).
module ams_ctrl
    import ams_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_WRITE = 6'b000010,
        S_SCAN  = 6'b000100,
        S_DRAIN = 6'b001000,
        S_MOD   = 6'b010000,
        S_EMIT  = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   in_fire;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_fire    = i_in_valid && o_in_ready;

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.load = in_fire;
                if (in_fire && i_stat.start_ok) begin
                    n_state = S_WRITE;
                end
            end
            S_WRITE: begin
                o_cmd.wr_en = 1'b1;
                if (i_stat.sens_last) begin
                    n_state = i_stat.filling ? S_MOD : S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.rd_en = 1'b1;
                if (i_stat.scan_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                // last read folds into the minimum here
                n_state = S_MOD;
            end
            S_MOD: begin
                o_cmd.mod_step = 1'b1;
                if (i_stat.mod_done) begin
                    o_cmd.commit = 1'b1;
                    n_state      = i_stat.filling ? S_IDLE : S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

>>> hdl/ams_dpath.sv
// Datapath: window memory, per-board slot/fill state, minimum scan,
// slot wrap by repeated subtraction, saturating subtract and output register.
// Depends on ams_pkg and assert_macros.svh.
`include "assert_macros.svh"
module ams_dpath
    import ams_pkg::*;
#(
    parameter int NUM_BOARDS = DEF_NUM_BOARDS,
    parameter int MAX_WINDOW = DEF_MAX_WINDOW
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_item  i_in_item,
    input  logic      i_cfg_valid,
    input  t_wlen     i_cfg_data,
    input  t_dp_cmd   i_cmd,
    output t_dp_stat  o_stat,
    input  logic      i_out_ready,
    output logic      o_out_valid,
    output t_out_item o_out_item
);

    localparam int NUM_ROWS = NUM_BOARDS * MAX_WINDOW;
    localparam int DEPTH    = NUM_ROWS * NUM_SENSORS;
    localparam int ROW_W    = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;
    localparam int ADDR_W   = $clog2(DEPTH);
    localparam int BRD_W    = (NUM_BOARDS > 1) ? $clog2(NUM_BOARDS) : 1;
    localparam int SLOT_W   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int CNT_W    = $clog2(MAX_WINDOW + 1);
    localparam int WLEN_MAX = (1 << WLEN_W) - 1;
    localparam int WLEN_RST = (MAX_WINDOW > WLEN_MAX) ? WLEN_MAX : MAX_WINDOW;

    // Configuration and per-board state
    t_wlen             r_wlen;
    logic [SLOT_W-1:0] r_wslot [NUM_BOARDS];
    logic [CNT_W-1:0]  r_fill  [NUM_BOARDS];
    logic [NUM_ROWS-1:0] r_row_vld;

    // Current item
    t_wlen             r_n;
    logic [BRD_W-1:0]  r_board;
    logic [SLOT_W-1:0] r_slot;
    logic [ROW_W-1:0]  r_brow;
    t_word             r_vref;
    t_word             r_raw [NUM_SENSORS];
    logic [SENS_W-1:0] r_scnt;
    logic [SLOT_W-1:0] r_kcnt;
    logic [CNT_W-1:0]  r_rem;

    // Memory and scan
    t_word r_mem [DEPTH];
    t_word r_q;
    logic  r_q_vld;
    logic  r_pend;
    t_word r_min;

    // Output register
    logic      r_out_valid;
    t_out_item r_out;

    logic [BRD_W-1:0]  in_bidx;
    logic [SLOT_W-1:0] in_slot_raw;
    logic [SLOT_W-1:0] in_slot;
    t_word             in_raw [NUM_SENSORS];
    logic [SLOT_W-1:0] row_off;
    logic [ROW_W-1:0]  row_idx;
    logic [ADDR_W-1:0] mem_addr;
    logic [CNT_W-1:0]  n_ext;
    t_word             fold_val;
    t_word             res [NUM_SENSORS];
    t_word             eye [NUM_SENSORS];
    t_out_item         n_out;

    // Incoming item decode
    assign in_bidx     = BRD_W'(i_in_item.board);
    assign in_slot_raw = r_wslot[in_bidx];
    assign in_slot     = (32'(in_slot_raw) >= MAX_WINDOW) ? '0 : in_slot_raw;

    always_comb begin
        in_raw[0] = i_in_item.raw_1;
        in_raw[1] = i_in_item.raw_2;
        in_raw[2] = i_in_item.raw_3;
        in_raw[3] = i_in_item.raw_4;
        in_raw[4] = i_in_item.raw_5;
        in_raw[5] = i_in_item.raw_6;
        in_raw[6] = i_in_item.raw_7;
    end

    // Memory address: board base row plus slot (store) or scan row
    assign row_off  = i_cmd.rd_en ? r_kcnt : r_slot;
    assign row_idx  = r_brow + ROW_W'(row_off);
    assign mem_addr = ADDR_W'(row_idx) * ADDR_W'(NUM_SENSORS) + ADDR_W'(r_scnt);

    assign n_ext    = CNT_W'(r_n);
    assign fold_val = r_q_vld ? r_q : '0;

    // Status to the controller
    always_comb begin
        o_stat.start_ok  = (r_wlen != '0) && (32'(i_in_item.board) < NUM_BOARDS);
        o_stat.sens_last = (r_scnt == SENS_W'(NUM_SENSORS - 1));
        o_stat.scan_last = (r_scnt == SENS_W'(NUM_SENSORS - 1))
                           && ((32'(r_kcnt) + 1) == 32'(r_n));
        o_stat.filling   = (32'(r_fill[r_board]) < 32'(r_n));
        o_stat.mod_done  = (r_rem < n_ext);
        o_stat.out_free  = !r_out_valid || i_out_ready;
    end

    // Saturating subtract and eye reorder
    always_comb begin
        for (int k = 0; k < NUM_SENSORS; k++) begin
            res[k] = (r_raw[k] > r_min) ? (r_raw[k] - r_min) : '0;
        end
        for (int k = 0; k < NUM_SENSORS; k++) begin
            eye[k] = res[EYE_SRC[k]];
        end
        n_out.vref_out = r_vref;
        n_out.eye_1    = eye[0];
        n_out.eye_2    = eye[1];
        n_out.eye_3    = eye[2];
        n_out.eye_4    = eye[3];
        n_out.eye_5    = eye[4];
        n_out.eye_6    = eye[5];
        n_out.eye_7    = eye[6];
    end

    // Window memory: one write or one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[mem_addr] <= r_raw[r_scnt];
        end
        if (i_cmd.rd_en) begin
            r_q     <= r_mem[mem_addr];
            r_q_vld <= r_row_vld[row_idx];
        end
    end

    // Control state: config, per-board slot/fill, row valid bits, flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wlen      <= t_wlen'(WLEN_RST);
            r_row_vld   <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
            for (int b = 0; b < NUM_BOARDS; b++) begin
                r_wslot[b] <= '0;
                r_fill[b]  <= '0;
            end
        end else begin
            if (i_cfg_valid) begin
                r_wlen <= (32'(i_cfg_data) > MAX_WINDOW) ? t_wlen'(MAX_WINDOW) : i_cfg_data;
            end
            if (i_cmd.wr_en) begin
                r_row_vld[row_idx] <= 1'b1;
            end
            r_pend <= i_cmd.rd_en;
            if (i_cmd.commit) begin
                r_wslot[r_board] <= SLOT_W'(r_rem);
                if (o_stat.filling) begin
                    r_fill[r_board] <= r_fill[r_board] + CNT_W'(1);
                end
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Item registers, counters, running minimum, remainder
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_n     <= r_wlen;
            r_board <= in_bidx;
            r_slot  <= in_slot;
            r_brow  <= ROW_W'(32'(in_bidx) * MAX_WINDOW);
            r_rem   <= CNT_W'(in_slot) + CNT_W'(1);
            r_vref  <= i_in_item.vref_word;
            for (int k = 0; k < NUM_SENSORS; k++) begin
                r_raw[k] <= in_raw[k];
            end
            r_scnt  <= '0;
            r_kcnt  <= '0;
            r_min   <= DATA_MAX;
        end else begin
            // sensor counter walks a row; scan also steps the row counter
            if (i_cmd.wr_en || i_cmd.rd_en) begin
                if (r_scnt == SENS_W'(NUM_SENSORS - 1)) begin
                    r_scnt <= '0;
                    if (i_cmd.rd_en) begin
                        r_kcnt <= r_kcnt + SLOT_W'(1);
                    end
                end else begin
                    r_scnt <= r_scnt + SENS_W'(1);
                end
            end
            if (r_pend && (fold_val < r_min)) begin
                r_min <= fold_val;
            end
            if (i_cmd.mod_step && !o_stat.mod_done) begin
                r_rem <= r_rem - n_ext;
            end
        end
        if (i_cmd.emit) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    `AMS_ASSERT_IMP(a_emit_free, i_clk, i_rst_n, i_cmd.emit, o_stat.out_free, "result overwrote an untaken item")
    `AMS_ASSERT(a_emit_valid, i_clk, i_rst_n, i_cmd.emit |=> r_out_valid, "output not valid after emit")
    `AMS_ASSERT_IMP(a_commit_rem, i_clk, i_rst_n, i_cmd.commit, (r_rem < n_ext), "slot committed beyond window")
    `AMS_ASSERT_IMP(a_scan_row, i_clk, i_rst_n, i_cmd.rd_en, (32'(r_kcnt) < 32'(r_n)), "scan past window length")

endmodule
